// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bsil_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bsil_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;
  localparam int TAG_W        = 10;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int OP_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_PUT,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic scan_init;
    logic pos_zero;
    logic mem_rd;
    logic shift_wr;
    logic idx_dec;
    logic pos_next;
    logic set_drop;
    logic put_new;
    logic load_res;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic [OP_W-1:0] op;
    logic            empty;
    logic            in_rd_ok;
    logic            gt;
    logic            idx_zero;
    logic            at_cap;
    logic            out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/bsil_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface bsil_in_if
  import bsil_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [KEY_W-1:0] new_key;
  logic [TAG_W-1:0] new_tag;
  logic [IDX_W-1:0] read_index;

  modport source (output valid, opcode, new_key, new_tag, read_index, input ready);
  modport sink (input valid, opcode, new_key, new_tag, read_index, output ready);
endinterface

interface bsil_out_if
  import bsil_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] insert_position;
  logic             dropped;
  logic             read_valid;
  logic [KEY_W-1:0] read_key;
  logic [TAG_W-1:0] read_tag;

  modport source (output valid, entry_count, insert_position, dropped, read_valid,
                  read_key, read_tag, input ready);
  modport sink (input valid, entry_count, insert_position, dropped, read_valid,
                read_key, read_tag, output ready);
endinterface
`default_nettype wire

// ----- hdl/bsil_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bsil_ctrl
  import bsil_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.in_op == OP_INSERT) begin
            state_next = sts.empty ? ST_PUT : ST_RD;
          end else if (sts.in_op == OP_READ && sts.in_rd_ok) begin
            state_next = ST_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RD: begin
        state_next = (sts.op == OP_READ) ? ST_DONE : ST_CMP;
      end
      ST_CMP: begin
        if (sts.gt) begin
          state_next = sts.idx_zero ? ST_PUT : ST_RD;
        end else begin
          state_next = sts.at_cap ? ST_DONE : ST_PUT;
        end
      end
      ST_PUT: state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (sts.in_op == OP_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (sts.in_op == OP_INSERT) begin
            cmd.scan_init = ~sts.empty;
            cmd.pos_zero  = sts.empty;
          end
        end
      end
      ST_RD: cmd.mem_rd = 1'b1;
      ST_CMP: begin
        if (sts.gt) begin
          cmd.shift_wr = 1'b1;
          cmd.pos_zero = sts.idx_zero;
          cmd.idx_dec  = ~sts.idx_zero;
        end else begin
          cmd.pos_next = 1'b1;
          cmd.set_drop = sts.at_cap;
        end
      end
      ST_PUT: cmd.put_new = 1'b1;
      ST_DONE: cmd.load_res = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/bsil_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bsil_dp
  import bsil_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire [OP_W-1:0]        opcode,
  input  wire [KEY_W-1:0]       new_key,
  input  wire [TAG_W-1:0]       new_tag,
  input  wire [IDX_W-1:0]       read_index,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  bsil_out_if.source            out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_W + TAG_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [EW-1:0]    mem [CAPACITY];
  logic [EW-1:0]    rdata;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] key;
  logic [TAG_W-1:0] tag;
  logic [CW-1:0]    held;
  logic [AW-1:0]    idx;
  logic [CW-1:0]    pos;
  logic             drop;
  logic             rvalid;

  logic [CW-1:0]       held_m1;
  logic [CW-1:0]       idx_p1;
  logic [AW+IDX_W-1:0] ridx_ext;
  logic [CW+IDX_W-1:0] ridx_cmp;
  logic [CW+IDX_W-1:0] held_cmp;
  logic                rd_ok;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;
  logic [CW+CNT_W-1:0] held_out;
  logic [CW+CNT_W-1:0] pos_out;

  assign held_m1  = held - CW'(1);
  assign idx_p1   = CW'(idx) + CW'(1);
  assign ridx_ext = {{AW{1'b0}}, read_index};
  assign ridx_cmp = {{CW{1'b0}}, read_index};
  assign held_cmp = {{IDX_W{1'b0}}, held};
  assign rd_ok    = ridx_cmp < held_cmp;
  assign held_out = {{CNT_W{1'b0}}, held};
  assign pos_out  = {{CNT_W{1'b0}}, pos};

  // Status toward the controller
  always_comb begin
    sts          = '0;
    sts.in_op    = opcode;
    sts.op       = op;
    sts.empty    = (held == '0);
    sts.in_rd_ok = rd_ok;
    sts.gt       = rdata[EW-1:TAG_W] > key;
    sts.idx_zero = (idx == '0);
    sts.at_cap   = (idx_p1 == CAP_C);
    sts.out_free = ~out_ch.valid | out_ch.ready;
  end

  // Capture the item and walk the scan index
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= opcode;
      key    <= new_key;
      tag    <= new_tag;
      idx    <= ridx_ext[AW-1:0];
      rvalid <= (opcode == OP_READ) && rd_ok;
    end
    if (cmd.scan_init) begin
      idx <= held_m1[AW-1:0];
    end
    if (cmd.idx_dec) begin
      idx <= idx - AW'(1);
    end
  end

  // Track position and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      drop <= 1'b0;
    end else begin
      if (cmd.capture) begin
        pos  <= '0;
        drop <= 1'b0;
      end
      if (cmd.pos_zero) begin
        pos <= '0;
      end
      if (cmd.pos_next) begin
        pos <= idx_p1;
      end
      if (cmd.set_drop) begin
        drop <= 1'b1;
      end
    end
  end

  // Count held entries
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.clear) begin
      held <= '0;
    end else if (cmd.put_new && held != CAP_C) begin
      held <= held + CW'(1);
    end
  end

  // Single write port: shift an entry up, or place the new one
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_p1[AW-1:0];
    wr_data = rdata;
    if (cmd.put_new) begin
      wr_en   = 1'b1;
      wr_addr = pos[AW-1:0];
      wr_data = {key, tag};
    end else if (cmd.shift_wr && idx_p1 != CAP_C) begin
      wr_en = 1'b1;
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[idx];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.load_res) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      out_ch.entry_count     <= held_out[CNT_W-1:0];
      out_ch.insert_position <= (op == OP_INSERT) ? pos_out[CNT_W-1:0] : '0;
      out_ch.dropped         <= drop;
      out_ch.read_valid      <= rvalid;
      out_ch.read_key        <= rvalid ? rdata[EW-1:TAG_W] : '0;
      out_ch.read_tag        <= rvalid ? rdata[TAG_W-1:0] : '0;
    end
  end

  `ASSERT_CLK(a_held_bound, clk, rst, held <= CAP_C, "held count above capacity")
  `ASSERT_CLK(a_clear_empties, clk, rst, cmd.clear |=> held == '0, "clear left entries")
  `ASSERT_CLK(a_drop_full, clk, rst, cmd.set_drop |-> held == CAP_C, "drop while not full")
  `ASSERT_CLK(a_one_write, clk, rst, !(cmd.put_new && cmd.shift_wr), "write port conflict")

endmodule
`default_nettype wire

// ----- hdl/bounded_sorted_insert_list.sv -----
// Operation: clear and read run from accept to result, a valid read through one
// entry read; an insert reads and compares each entry above its sorted position
// and the first at or below it, shifting larger ones up, then places or drops it.
// Throughput: one item at a time, held while a result waits for the receiver; the
// memory scan (one entry read, then compare and shift write, per entry) sets the rate.
// Reset: synchronous, active high; empties the list and the result register.
`timescale 1ns / 1ps
`default_nettype none
module bounded_sorted_insert_list
  import bsil_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire         clk,
  input wire         rst,
  bsil_in_if.sink    in_ch,
  bsil_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  bsil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsil_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .opcode     (in_ch.opcode),
    .new_key    (in_ch.new_key),
    .new_tag    (in_ch.new_tag),
    .read_index (in_ch.read_index),
    .cmd        (cmd),
    .sts        (sts),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ----- tb/bounded_sorted_insert_list_test.sv -----
`timescale 1ns / 1ps
module bounded_sorted_insert_list_test;
  import bsil_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] insert_position;
    logic             dropped;
    logic             read_valid;
    logic [KEY_W-1:0] read_key;
    logic [TAG_W-1:0] read_tag;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsil_in_if  in_ch();
  bsil_out_if out_ch();

  bounded_sorted_insert_list dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the list
  logic [KEY_W-1:0] shadow_key [CAP];
  logic [TAG_W-1:0] shadow_tag [CAP];
  int unsigned      shadow_count;

  list_result_t pending_results[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         hold_off = 1'b0;
  event         hold_off_go;
  int unsigned  error_count = 0;
  int unsigned  result_count = 0;
  int unsigned  drop_count = 0;
  int unsigned  full_count = 0;
  longint unsigned cycle_count = 0;

  // Apply one operation to the shadow list and produce the expected result
  function automatic list_result_t predict_list_op(logic [OP_W-1:0] op,
      logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, logic [IDX_W-1:0] idx);
    list_result_t r;
    int unsigned pos;
    int unsigned n;
    r = '0;
    case (op)
      OP_CLEAR: begin
        shadow_count = 0;
      end
      OP_INSERT: begin
        pos = shadow_count;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_key[i] > key) begin
            pos = i;
            break;
          end
        end
        r.insert_position = pos[CNT_W-1:0];
        if (pos >= CAP) begin
          r.dropped = 1'b1;
        end else begin
          n = (shadow_count >= CAP) ? CAP - 1 : shadow_count;
          for (int i = n; i > pos; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_tag[i] = shadow_tag[i-1];
          end
          shadow_key[pos] = key;
          shadow_tag[pos] = tag;
          shadow_count = n + 1;
        end
      end
      OP_READ: begin
        if (idx < shadow_count) begin
          r.read_valid = 1'b1;
          r.read_key   = shadow_key[idx];
          r.read_tag   = shadow_tag[idx];
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  // Offer one item, with random idle ahead of it, and wait for its accept
  task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
      logic [TAG_W-1:0] tag, logic [IDX_W-1:0] idx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.new_key    <= key;
    in_ch.new_tag    <= tag;
    in_ch.read_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_INSERT && shadow_count == CAP) full_count++;
    pending_results.push_back(predict_list_op(op, key, tag, idx));
    @(negedge clk);
  endtask

  // Drop valid and wait for every expected result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Long receiver hold-off, counted in its own process
  initial begin
    forever begin
      @(hold_off_go);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clk);
      hold_off <= 1'b0;
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    list_result_t got;
    list_result_t exp;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.entry_count, out_ch.insert_position, out_ch.dropped,
              out_ch.read_valid, out_ch.read_key, out_ch.read_tag};
      result_count++;
      if (got.dropped) drop_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        exp = pending_results.pop_front();
        if (got.entry_count !== exp.entry_count)
          $display("%0t: entry_count exp %0d got %0d", $time, exp.entry_count,
                   got.entry_count);
        if (got.insert_position !== exp.insert_position)
          $display("%0t: insert_position exp %0d got %0d", $time,
                   exp.insert_position, got.insert_position);
        if (got.dropped !== exp.dropped)
          $display("%0t: dropped exp %0b got %0b", $time, exp.dropped, got.dropped);
        if (got.read_valid !== exp.read_valid)
          $display("%0t: read_valid exp %0b got %0b", $time, exp.read_valid,
                   got.read_valid);
        if (got.read_key !== exp.read_key)
          $display("%0t: read_key exp %h got %h", $time, exp.read_key, got.read_key);
        if (got.read_tag !== exp.read_tag)
          $display("%0t: read_tag exp %h got %h", $time, exp.read_tag, got.read_tag);
        if (got !== exp) error_count++;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[bounded_sorted_insert_list] ERROR");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] rand_key(bit narrow);
    return narrow ? KEY_W'($urandom_range(15)) : KEY_W'($urandom);
  endfunction

  task automatic test_directed();
    send_item(OP_READ, '0, '0, 6'd0);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 10'h3FF, '0);
    send_item(OP_INSERT, 32'h0, 10'h000, '0);
    send_item(OP_INSERT, 32'h5, 10'h155, '0);
    send_item(OP_INSERT, 32'h5, 10'h2AA, '0);
    for (int i = 0; i < 5; i++) send_item(OP_READ, '0, '0, IDX_W'(i));
    send_item(OP_READ, '0, '0, 6'd63);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 10'h3FF, 6'd63);
    send_item(OP_CLEAR, 32'hFFFF_FFFF, 10'h3FF, 6'd63);
    send_item(OP_READ, '0, '0, 6'd0);
    drain_results();
  endtask

  // Fill the list, then drop at the end and displace from inside
  task automatic test_full_list();
    send_item(OP_CLEAR, '0, '0, '0);
    for (int i = 0; i < CAP; i++)
      send_item(OP_INSERT, KEY_W'(i * 4 + 8), TAG_W'(i), '0);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 10'h3FF, '0);
    send_item(OP_INSERT, KEY_W'(CAP * 4 + 4), 10'h001, '0);
    send_item(OP_INSERT, 32'h0, 10'h3FE, '0);
    send_item(OP_INSERT, 32'h20, 10'h2AA, '0);
    send_item(OP_READ, '0, '0, 6'd63);
    send_item(OP_READ, '0, '0, 6'd0);
    drain_results();
  endtask

  // Random phase: mostly inserts with reads, occasional clears and noise
  task automatic test_random(int unsigned items, int unsigned idle,
      int unsigned stall);
    int unsigned pick;
    bit narrow;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      narrow = ($urandom_range(3) == 0);
      if (pick < 2)
        send_item(OP_CLEAR, KEY_W'($urandom), TAG_W'($urandom), IDX_W'($urandom));
      else if (pick < 4)
        send_item(OP_UNUSED, KEY_W'($urandom), TAG_W'($urandom), IDX_W'($urandom));
      else if (pick < 60)
        send_item(OP_INSERT, rand_key(narrow), TAG_W'($urandom), IDX_W'($urandom));
      else
        send_item(OP_READ, KEY_W'($urandom), TAG_W'($urandom), IDX_W'($urandom));
    end
    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Hold the receiver off long enough for the block to stall its input
  task automatic test_backpressure();
    -> hold_off_go;
    for (int i = 0; i < 20; i++)
      send_item(OP_INSERT, KEY_W'($urandom), TAG_W'($urandom), '0);
    drain_results();
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_CLEAR;
    in_ch.new_key    = '0;
    in_ch.new_tag    = '0;
    in_ch.read_index = '0;
    shadow_count     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_list();
    test_backpressure();
    test_random(350, 0, 0);
    test_random(350, 50, 0);
    test_random(350, 0, 50);
    test_random(350, 17, 17);

    repeat (2 * CAP + 10) @(negedge clk);
    $display("Covered %0d results: %0d drops, %0d inserts into a full list.",
             result_count, drop_count, full_count);
    $display("Phases: directed, full list, long hold-off, four random idle mixes.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[bounded_sorted_insert_list] OK");
    end else begin
      $display("[bounded_sorted_insert_list] ERROR");
    end
    $finish;
  end

endmodule
